// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/core/kwm_pkg.sv -----
// Package with the shared constants, types and helpers of the keyword table matcher.
`default_nettype none

package kwm_pkg;

    localparam int NUM_KEYWORDS = 16;
    localparam int MAX_KEY_LEN  = 32;

    localparam int IDX_W   = $clog2(NUM_KEYWORDS);
    localparam int NUM_W   = $clog2(NUM_KEYWORDS + 1);
    localparam int LEN_W   = $clog2(MAX_KEY_LEN + 1);
    localparam int ADDR_W  = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
    localparam int CHAR_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = NUM_W;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_EXACT_MATCH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CASE_SENSITIVE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYWORD_COUNT  = 2'd2;

    // Request action codes.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TEST = 1'b1;

    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [LEN_W-1:0]  len_t;
    typedef char_t [NUM_KEYWORDS-1:0] kw_chars_t;
    typedef len_t  [NUM_KEYWORDS-1:0] kw_lens_t;

    typedef struct packed {
        logic             exact_match;
        logic             case_sensitive;
        logic [NUM_W-1:0] keyword_count;
    } cfg_t;

    typedef struct packed {
        logic             char_we;
        logic             len_we;
        logic [IDX_W-1:0] idx;
        len_t             pos;
        char_t            value;
    } tbl_wr_t;

    // ASCII a-z fold to A-Z unless the compare is case sensitive.
    function automatic char_t fold_char(input char_t c, input logic case_sensitive);
        char_t r;
        r = c;
        if (!case_sensitive && c >= 8'h61 && c <= 8'h7A)
        begin
            r = c - 8'h20;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/kwm_ram.sv -----
// Generic single-port-write, registered-read RAM.
`default_nettype none

module kwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                              clk,
    input  wire logic                              we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                  wdata,
    input  wire logic                              re,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic      [WIDTH-1:0]                  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/kwm_table.sv -----
// Keyword table: one character RAM bank per keyword and the keyword length registers.
`default_nettype none

module kwm_table (
    input  wire logic                           clk,
    input  wire kwm_pkg::tbl_wr_t               wr,
    input  wire logic                           rd_en,
    input  wire logic [kwm_pkg::ADDR_W-1:0]     rd_addr,
    output kwm_pkg::kw_chars_t                  rd_data,
    output kwm_pkg::kw_lens_t                   lengths
);

    kwm_pkg::kw_lens_t lengths_reg;

    for (genvar g = 0; g < kwm_pkg::NUM_KEYWORDS; g++)
    begin : g_bank
        kwm_ram #(
            .WIDTH (kwm_pkg::CHAR_W),
            .DEPTH (kwm_pkg::MAX_KEY_LEN)
        ) u_ram (
            .clk   (clk),
            .we    (wr.char_we && (wr.idx == kwm_pkg::IDX_W'(g))),
            .waddr (wr.pos[kwm_pkg::ADDR_W-1:0]),
            .wdata (wr.value),
            .re    (rd_en),
            .raddr (rd_addr),
            .rdata (rd_data[g])
        );
    end

    always_ff @(posedge clk)
    begin
        if (wr.len_we)
        begin
            lengths_reg[wr.idx] <= wr.pos;
        end
    end

    assign lengths = lengths_reg;

endmodule

`default_nettype wire

// ----- rtl/core/kwm_match.sv -----
// Compare stage: per-keyword alive bits, terminator decision and the result register.
`default_nettype none

module kwm_match (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire kwm_pkg::cfg_t              cfg,
    input  wire logic                       take,
    input  wire kwm_pkg::char_t             take_char,
    input  wire kwm_pkg::len_t              take_pos,
    input  wire kwm_pkg::kw_chars_t         rd_data,
    input  wire kwm_pkg::kw_lens_t          lengths,
    output logic                            stage_ready,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [kwm_pkg::NUM_W-1:0]       match_number,
    output kwm_pkg::len_t                   matched_length
);

    logic                               s1_valid_reg, s1_valid_next;
    kwm_pkg::char_t                     s1_char_reg;
    kwm_pkg::len_t                      s1_pos_reg;
    logic [kwm_pkg::NUM_KEYWORDS-1:0]   alive_reg, alive_next;
    logic                               out_valid_reg, out_valid_next;
    logic [kwm_pkg::NUM_W-1:0]          number_reg;
    kwm_pkg::len_t                      length_reg;

    logic                               s1_term;
    logic                               s1_go;
    logic [kwm_pkg::NUM_KEYWORDS-1:0]   kill;
    logic [kwm_pkg::NUM_KEYWORDS-1:0]   hit;
    logic [kwm_pkg::NUM_W-1:0]          cnt_eff;
    logic [kwm_pkg::NUM_W-1:0]          number_sel;
    kwm_pkg::len_t                      length_sel;
    kwm_pkg::char_t                     fc;

    assign s1_term     = (s1_char_reg == '0);
    assign s1_go       = s1_valid_reg && (!s1_term || !out_valid_reg || out_ready);
    assign stage_ready = !s1_valid_reg || s1_go;

    always_comb
    begin
        fc      = kwm_pkg::fold_char(s1_char_reg, cfg.case_sensitive);
        cnt_eff = (cfg.keyword_count > kwm_pkg::NUM_W'(kwm_pkg::NUM_KEYWORDS))
                ? kwm_pkg::NUM_W'(kwm_pkg::NUM_KEYWORDS) : cfg.keyword_count;
        for (int i = 0; i < kwm_pkg::NUM_KEYWORDS; i++)
        begin
            // Inside the keyword a byte must match; past its end only exact mode cares.
            if (s1_pos_reg < lengths[i])
            begin
                kill[i] = alive_reg[i]
                    && (kwm_pkg::fold_char(rd_data[i], cfg.case_sensitive) != fc);
            end
            else
            begin
                kill[i] = alive_reg[i] && cfg.exact_match;
            end
            hit[i] = alive_reg[i] && (kwm_pkg::NUM_W'(i) < cnt_eff)
                && (cfg.exact_match ? (lengths[i] == s1_pos_reg)
                                    : (lengths[i] <= s1_pos_reg));
        end
        // The lowest-numbered hit wins.
        number_sel = '0;
        length_sel = '0;
        for (int i = kwm_pkg::NUM_KEYWORDS - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                number_sel = kwm_pkg::NUM_W'(i + 1);
                length_sel = lengths[i];
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end

        alive_next = alive_reg;
        if (s1_go)
        begin
            alive_next = s1_term ? '1 : (alive_reg & ~kill);
        end

        out_valid_next = out_valid_reg;
        if (s1_go && s1_term)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            alive_reg     <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            alive_reg     <= alive_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_char_reg <= take_char;
            s1_pos_reg  <= take_pos;
        end
        if (s1_go && s1_term)
        begin
            number_reg <= number_sel;
            length_reg <= length_sel;
        end
    end

    assign out_valid      = out_valid_reg;
    assign match_number   = number_reg;
    assign matched_length = length_reg;

endmodule

`default_nettype wire

// ----- rtl/core/keyword_table_matcher.sv -----
// Top level of the keyword table matcher: configuration, input stage and string position.
// One request is accepted per cycle whenever the compare stage can move on. Load requests
// write a keyword byte or length when accepted. A string byte reads the byte at the running
// string position from all sixteen keyword RAM banks at once (registered read) and is
// compared against every keyword in the next cycle. A terminator's result is registered in the
// compare stage and then in the output register; while that result waits to be taken a
// following terminator holds in the compare stage and stops input, everything else flows
// at one request per cycle. Keyword bytes and lengths have no reset and must be loaded
// before use; there is no clearing pass after reset.
`default_nettype none

module keyword_table_matcher (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               action,
    input  wire logic [kwm_pkg::IDX_W-1:0]          keyword_index,
    input  wire logic [kwm_pkg::LEN_W-1:0]          char_position,
    input  wire logic [kwm_pkg::CHAR_W-1:0]         char_value,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [kwm_pkg::NUM_W-1:0]               match_number,
    output logic [kwm_pkg::LEN_W-1:0]               matched_length,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [kwm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [kwm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    kwm_pkg::cfg_t      cfg_reg, cfg_next;
    kwm_pkg::len_t      pos_reg, pos_next;
    kwm_pkg::tbl_wr_t   wr;
    kwm_pkg::kw_chars_t rd_data;
    kwm_pkg::kw_lens_t  lengths;
    logic               accept;
    logic               take;
    logic               stage_ready;

    assign cfg_ready = 1'b1;
    assign in_ready  = stage_ready;
    assign accept    = in_valid && in_ready;
    assign take      = accept && (action == kwm_pkg::ACT_TEST);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                kwm_pkg::CFG_EXACT_MATCH:    cfg_next.exact_match    = cfg_data[0];
                kwm_pkg::CFG_CASE_SENSITIVE: cfg_next.case_sensitive = cfg_data[0];
                kwm_pkg::CFG_KEYWORD_COUNT:  cfg_next.keyword_count  = cfg_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    // The position counter runs at the input side so the RAM read can start on accept.
    always_comb
    begin
        pos_next = pos_reg;
        if (take)
        begin
            if (char_value == '0)
            begin
                pos_next = '0;
            end
            else if (pos_reg < kwm_pkg::LEN_W'(kwm_pkg::MAX_KEY_LEN))
            begin
                pos_next = pos_reg + kwm_pkg::LEN_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.exact_match    <= 1'b0;
            cfg_reg.case_sensitive <= 1'b1;
            cfg_reg.keyword_count  <= '0;
            pos_reg                <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            pos_reg <= pos_next;
        end
    end

    always_comb
    begin
        wr.idx     = keyword_index;
        wr.pos     = char_position;
        wr.value   = char_value;
        wr.char_we = accept && (action == kwm_pkg::ACT_LOAD) && (char_value != '0)
                  && (char_position < kwm_pkg::LEN_W'(kwm_pkg::MAX_KEY_LEN));
        wr.len_we  = accept && (action == kwm_pkg::ACT_LOAD) && (char_value == '0)
                  && (char_position <= kwm_pkg::LEN_W'(kwm_pkg::MAX_KEY_LEN));
    end

    kwm_table u_table (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (take),
        .rd_addr (pos_reg[kwm_pkg::ADDR_W-1:0]),
        .rd_data (rd_data),
        .lengths (lengths)
    );

    kwm_match u_match (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .take           (take),
        .take_char      (char_value),
        .take_pos       (pos_reg),
        .rd_data        (rd_data),
        .lengths        (lengths),
        .stage_ready    (stage_ready),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .match_number   (match_number),
        .matched_length (matched_length)
    );

endmodule

`default_nettype wire

// ----- rtl/core/kwm_checker.sv -----
// Port-level checker for the keyword table matcher and its bind statement.
`default_nettype none
`include "assert_macros.svh"

module kwm_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               in_valid,
    input wire logic                               in_ready,
    input wire logic                               action,
    input wire logic [kwm_pkg::CHAR_W-1:0]         char_value,
    input wire logic                               out_valid,
    input wire logic                               out_ready,
    input wire logic [kwm_pkg::NUM_W-1:0]          match_number,
    input wire logic [kwm_pkg::LEN_W-1:0]          matched_length,
    input wire logic                               cfg_valid,
    input wire logic                               cfg_ready
);

    logic                                          out_wait;
    logic                                          result_ok;
    logic                                          term_accept;
    logic [kwm_pkg::NUM_W+kwm_pkg::LEN_W-1:0]      result_bits;

    assign out_wait    = out_valid && !out_ready;
    assign result_bits = {match_number, matched_length};
    assign result_ok   = (match_number != '0 || matched_length == '0)
        && (match_number <= kwm_pkg::NUM_W'(kwm_pkg::NUM_KEYWORDS))
        && (matched_length <= kwm_pkg::LEN_W'(kwm_pkg::MAX_KEY_LEN));
    assign term_accept = in_valid && in_ready && (action == kwm_pkg::ACT_TEST)
        && (char_value == '0);

    // A waiting result keeps its value.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_wait, out_valid && $stable(result_bits))

    // No match means a zero matched length, and a match never reports beyond the table.
    `ASSERT_SAME(a_result_range, clk, rst_n, out_valid, result_ok)

    // A fresh result traces back to an accepted terminator request.
    `ASSERT_SAME(a_result_source, clk, rst_n, $rose(out_valid), $past(term_accept, 2))

    // Configuration writes are never stalled.
    `ASSERT_SAME(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready)

endmodule

bind keyword_table_matcher kwm_checker u_kwm_checker (.*);

`default_nettype wire

// ----- tb/sv/keyword_table_matcher_tb.sv -----
// Self-checking testbench for the keyword table matcher with a queued driver and result monitor.
`timescale 1ns / 100ps

module keyword_table_matcher_tb;
    import kwm_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int PHASES          = 9;
    localparam int ITEMS_PER_PHASE = 95;
    localparam int MAX_PRINTS      = 50;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic             action;
        logic [IDX_W-1:0] idx;
        len_t             pos;
        char_t            value;
    } kw_req_t;

    typedef struct packed {
        logic [NUM_W-1:0] number;
        len_t             length;
    } kw_match_t;

    logic                  clk            = 1'b0;
    logic                  rst_n          = 1'b0;
    logic                  in_valid       = 1'b0;
    logic                  in_ready;
    logic                  action         = ACT_LOAD;
    logic [IDX_W-1:0]      keyword_index  = '0;
    len_t                  char_position  = '0;
    char_t                 char_value     = '0;
    logic                  out_valid;
    logic                  out_ready      = 1'b0;
    logic [NUM_W-1:0]      match_number;
    len_t                  matched_length;
    logic                  cfg_valid      = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;

    // Predicted matcher state.
    bit [CHAR_W-1:0]         kw_bytes [NUM_KEYWORDS][MAX_KEY_LEN];
    int unsigned             kw_lens [NUM_KEYWORDS];
    logic [NUM_KEYWORDS-1:0] alive        = '1;
    int unsigned             str_pos      = 0;
    logic                    exact_mode   = 1'b0;
    logic                    case_exact   = 1'b1;
    logic [CFG_DATA_W-1:0]   active_count = '0;

    // Table contents as the queued requests will leave it, used to build strings.
    bit [CHAR_W-1:0] plan_bytes [NUM_KEYWORDS][MAX_KEY_LEN];
    bit              plan_set [NUM_KEYWORDS][MAX_KEY_LEN];
    int              plan_lens [NUM_KEYWORDS];
    int              plan_count = 0;

    kw_req_t   pending_reqs[$];
    kw_match_t expected_matches[$];
    kw_req_t   cur_req;
    kw_match_t want_match;
    int        queued_reqs    = 0;
    int        mismatch_count = 0;
    int        cycle_count    = 0;
    int        send_gap_pct   = 9;
    int        stall_pct      = 86;

    keyword_table_matcher u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .keyword_index  (keyword_index),
        .char_position  (char_position),
        .char_value     (char_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .match_number   (match_number),
        .matched_length (matched_length),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(string msg);
        if (mismatch_count < MAX_PRINTS)
            $display("%0t ERROR %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic char_t upcase(char_t c);
        if (!case_exact && c >= 8'h61 && c <= 8'h7A)
            return c - 8'h20;
        return c;
    endfunction

    // Advances the predicted state by one accepted request.
    task automatic match_step(kw_req_t r);
        int        k;
        int        n;
        kw_match_t m;
        if (r.action == ACT_LOAD)
        begin
            if (r.value == 0)
            begin
                if (r.pos <= MAX_KEY_LEN)
                    kw_lens[r.idx] = r.pos;
            end
            else if (r.pos < MAX_KEY_LEN)
                kw_bytes[r.idx][r.pos] = r.value;
        end
        else if (r.value != 0)
        begin
            for (k = 0; k < NUM_KEYWORDS; k++)
            begin
                if (alive[k])
                begin
                    if (str_pos < kw_lens[k])
                    begin
                        if (upcase(kw_bytes[k][str_pos]) != upcase(r.value))
                            alive[k] = 1'b0;
                    end
                    else if (exact_mode)
                        alive[k] = 1'b0;
                end
            end
            if (str_pos < MAX_KEY_LEN)
                str_pos++;
        end
        else
        begin
            n = (active_count > NUM_KEYWORDS) ? NUM_KEYWORDS : active_count;
            m = '0;
            for (k = 0; k < n; k++)
            begin
                if (m.number == 0 && alive[k] &&
                    (exact_mode ? (kw_lens[k] == str_pos) : (kw_lens[k] <= str_pos)))
                begin
                    m.number = NUM_W'(k + 1);
                    m.length = LEN_W'(kw_lens[k]);
                end
            end
            expected_matches.push_back(m);
            alive   = '1;
            str_pos = 0;
        end
    endtask

    // Driver: presents queued requests and predicts each one as it is accepted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                match_step(cur_req);
            if (!in_valid || in_ready)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    cur_req = pending_reqs.pop_front();
                    in_valid      <= 1'b1;
                    action        <= cur_req.action;
                    keyword_index <= cur_req.idx;
                    char_position <= cur_req.pos;
                    char_value    <= cur_req.value;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compares every accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_matches.size() == 0)
                    report_mismatch($sformatf("unexpected result %0d/%0d",
                                              match_number, matched_length));
                else
                begin
                    want_match = expected_matches.pop_front();
                    if (match_number !== want_match.number)
                        report_mismatch($sformatf("match_number %0d, expected %0d",
                                                  match_number, want_match.number));
                    if (matched_length !== want_match.length)
                        report_mismatch($sformatf("matched_length %0d, expected %0d",
                                                  matched_length, want_match.length));
                end
            end
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic queue_req(logic act, int slot, int p, int v);
        kw_req_t r;
        r.action = act;
        r.idx    = IDX_W'(slot);
        r.pos    = LEN_W'(p);
        r.value  = CHAR_W'(v);
        pending_reqs.push_back(r);
        // Loads that the block drops are not counted as stimulus.
        if (act == ACT_TEST)
            queued_reqs++;
        else if (v == 0 && p <= MAX_KEY_LEN)
        begin
            plan_lens[slot] = p;
            queued_reqs++;
        end
        else if (v != 0 && p < MAX_KEY_LEN)
        begin
            plan_bytes[slot][p] = CHAR_W'(v);
            plan_set[slot][p]   = 1'b1;
            queued_reqs++;
        end
    endtask

    // The slot and position fields carry no meaning for string bytes, so they are random.
    task automatic queue_byte(int v);
        queue_req(ACT_TEST, $urandom_range(NUM_KEYWORDS - 1), $urandom_range(63), v);
    endtask

    task automatic queue_text(string s);
        int i;
        for (i = 0; i < s.len(); i++)
            queue_byte(s[i]);
        queue_byte(0);
    endtask

    task automatic queue_word(int slot, string s);
        int i;
        for (i = 0; i < s.len(); i++)
            queue_req(ACT_LOAD, slot, i, s[i]);
        queue_req(ACT_LOAD, slot, s.len(), 0);
    endtask

    function automatic char_t pick_char();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return CHAR_W'($urandom_range(255, 1));
        if (r < 4)
            return CHAR_W'(8'h61 + $urandom_range(3));
        return CHAR_W'(8'h41 + $urandom_range(3));
    endfunction

    function automatic char_t flip_case(char_t c);
        if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))
            return c ^ 8'h20;
        return c;
    endfunction

    task automatic queue_keyword(int slot, int n);
        int p;
        for (p = 0; p < n; p++)
            queue_req(ACT_LOAD, slot, p, pick_char());
        queue_req(ACT_LOAD, slot, n, 0);
    endtask

    // Number of keyword bytes written without a gap from position zero.
    function automatic int written_prefix(int slot);
        int n;
        n = 0;
        while (n < MAX_KEY_LEN && plan_set[slot][n])
            n++;
        return n;
    endfunction

    // A length is only set where every byte below it has been written.
    task automatic queue_noise();
        int slot;
        int pick;
        int r;
        slot = $urandom_range(NUM_KEYWORDS - 1);
        pick = $urandom_range(9);
        if (pick < 4)
        begin
            r = $urandom_range(19);
            if (r == 0)
                queue_keyword(slot, 0);
            else if (r == 1)
                queue_keyword(slot, MAX_KEY_LEN);
            else if (r < 5)
                queue_keyword(slot, $urandom_range(12, 6));
            else
                queue_keyword(slot, $urandom_range(5, 1));
        end
        else if (pick < 7)
            queue_req(ACT_LOAD, slot, $urandom_range(MAX_KEY_LEN - 1), pick_char());
        else if (pick < 9)
            queue_req(ACT_LOAD, slot, $urandom_range(written_prefix(slot)), 0);
        else if ($urandom_range(1) == 0)
            queue_req(ACT_LOAD, slot, $urandom_range(63, MAX_KEY_LEN + 1), 0);
        else
            queue_req(ACT_LOAD, slot, $urandom_range(63, MAX_KEY_LEN), pick_char());
    endtask

    // Most strings follow a keyword in play, with case flips, stray bytes and tails.
    task automatic queue_string();
        int    n;
        int    slot;
        int    cut;
        int    tail;
        int    r;
        int    p;
        char_t c;
        n = (plan_count > NUM_KEYWORDS) ? NUM_KEYWORDS : plan_count;
        if (n == 0)
            n = NUM_KEYWORDS;
        tail = $urandom_range(6);
        if ($urandom_range(9) < 7)
        begin
            slot = $urandom_range(n - 1);
            cut  = ($urandom_range(3) == 0) ? $urandom_range(plan_lens[slot]) : plan_lens[slot];
            for (p = 0; p < cut; p++)
            begin
                c = plan_bytes[slot][p];
                if ($urandom_range(3) == 0)
                    c = flip_case(c);
                if ($urandom_range(19) == 0)
                    c = pick_char();
                queue_byte(c);
                if ($urandom_range(24) == 0)
                    queue_req(ACT_LOAD, $urandom_range(NUM_KEYWORDS - 1),
                              $urandom_range(MAX_KEY_LEN - 1), pick_char());
            end
            r = $urandom_range(9);
            if (r < 5)
                tail = 0;
            else if (r < 9)
                tail = $urandom_range(4, 1);
            else
                tail = $urandom_range(38, 28);
        end
        for (p = 0; p < tail; p++)
            queue_byte(pick_char());
        queue_byte(0);
    endtask

    // Every slot gets a complete keyword before any slot takes part in matching.
    task automatic load_base_table();
        logic [31:0] border;
        int          i;
        border = 32'h405B607B;
        queue_word(0, "GOTO");
        queue_word(1, "GO");
        queue_word(2, "G");
        queue_word(3, "abc");
        queue_word(4, "ABCD");
        for (i = 0; i < MAX_KEY_LEN; i++)
            queue_req(ACT_LOAD, 5, i, (i % 3 == 0) ? 8'hFF : (i % 3 == 1) ? 8'h80 : 8'h01);
        queue_req(ACT_LOAD, 5, MAX_KEY_LEN, 0);
        for (i = 0; i < 4; i++)
            queue_req(ACT_LOAD, 6, i, border[31 - 8 * i -: 8]);
        queue_req(ACT_LOAD, 6, 4, 0);
        for (i = 7; i < NUM_KEYWORDS - 1; i++)
            queue_keyword(i, $urandom_range(6, 1));
        queue_req(ACT_LOAD, NUM_KEYWORDS - 1, 0, 0);
        // Loads beyond the table are dropped.
        queue_req(ACT_LOAD, 0, MAX_KEY_LEN + 1, 0);
        queue_req(ACT_LOAD, 0, 63, 0);
        queue_req(ACT_LOAD, 1, MAX_KEY_LEN, 8'h5A);
        queue_req(ACT_LOAD, 1, 63, 8'hFF);
    endtask

    task automatic queue_directed();
        int i;
        queue_text("GOTOX");
        queue_text("GOTO");
        queue_text("GO");
        queue_text("go");
        queue_text("G");
        queue_text("abcd");
        queue_text("ABCDE");
        queue_text("");
        // Punctuation next to the letter ranges must not fold.
        queue_byte(8'h60);
        queue_byte(8'h7B);
        queue_byte(8'h40);
        queue_byte(8'h5B);
        queue_byte(0);
        // The full-length keyword, then the same run past the saturation point.
        for (i = 0; i < MAX_KEY_LEN; i++)
            queue_byte((i % 3 == 0) ? 8'hFF : (i % 3 == 1) ? 8'h80 : 8'h01);
        queue_byte(0);
        for (i = 0; i < MAX_KEY_LEN + 3; i++)
            queue_byte((i % 3 == 0) ? 8'hFF : (i % 3 == 1) ? 8'h80 : 8'h01);
        queue_byte(0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_EXACT_MATCH:    exact_mode   = data[0];
            CFG_CASE_SENSITIVE: case_exact   = data[0];
            CFG_KEYWORD_COUNT:  active_count = data;
            default:            ;
        endcase
    endtask

    // Waits until every request is taken and every result is back, then lets the
    // pipeline settle so that trailing loads are written before the next write.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || in_valid || expected_matches.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int                    p;
        int                    ex;
        int                    cs;
        logic [CFG_DATA_W-1:0] word;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: no keyword takes part, so every string reports no match.
        load_base_table();
        queue_text("");
        queue_text("GO");
        wait_idle();

        for (p = 0; p < PHASES; p++)
        begin
            if (p < 3)
            begin
                send_gap_pct = 9;
                stall_pct    = 86;
            end
            else if (p < 6)
            begin
                send_gap_pct = 86;
                stall_pct    = 9;
            end
            else
            begin
                send_gap_pct = 0;
                stall_pct    = 0;
            end
            case (p)
                0:       begin ex = 0; cs = 1; plan_count = 16; end
                1:       begin ex = 1; cs = 0; plan_count = 16; end
                2:       begin ex = 0; cs = 0; plan_count = 31; end
                3:       begin ex = 1; cs = 1; plan_count = 1;  end
                4:       begin ex = 0; cs = 1; plan_count = 0;  end
                5:       begin ex = 1; cs = 0; plan_count = 17; end
                6:       begin ex = 1; cs = 0; plan_count = 5;  end
                7:       begin ex = 0; cs = 0; plan_count = 16; end
                default: begin ex = 0; cs = 1; plan_count = 10; end
            endcase
            word    = CFG_DATA_W'($urandom_range(31));
            word[0] = ex[0];
            write_reg(CFG_EXACT_MATCH, word);
            word    = CFG_DATA_W'($urandom_range(31));
            word[0] = cs[0];
            write_reg(CFG_CASE_SENSITIVE, word);
            write_reg(CFG_KEYWORD_COUNT, CFG_DATA_W'(plan_count));
            if (p == 4)
                write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(31)));
            if (p < 2)
                queue_directed();
            while (queued_reqs < ITEMS_PER_PHASE * (p + 1))
            begin
                if ($urandom_range(3) == 0)
                    queue_noise();
                queue_string();
            end
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/kwm_pkg.sv
rtl/core/kwm_ram.sv
rtl/core/kwm_table.sv
rtl/core/kwm_match.sv
rtl/core/keyword_table_matcher.sv
rtl/core/kwm_checker.sv
tb/sv/keyword_table_matcher_tb.sv
